// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the divider word calculator RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define PDW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define PDW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define PDW_ASSERT_IMP(lbl, ante, cons, msg)
`define PDW_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/pdw_pkg.sv =====
// ----------------------------------------------------------------------------
// pdw_pkg
// Types, constants and lookup functions of the PLL divider word calculator.
// ----------------------------------------------------------------------------
package pdw_pkg;

  localparam int FREQ_W  = 16;
  localparam int RDIV_W  = 10;
  localparam int PFD_W   = 8;
  localparam int EXP_W   = 3;
  localparam int WORD_W  = 32;
  localparam int CIDX_W  = 2;

  // Quotient bits resolved per divider stage, and the stage count.
  localparam int CHUNK   = 4;
  localparam int NSTG    = FREQ_W / CHUNK;

  // Reference frequency in 100 kHz units.
  localparam logic [RDIV_W-1:0] XTAL_UNITS = 10'd192;

  localparam logic [WORD_W-1:0] REG4_DIV_CLEAR = 32'hFF8F_FFFF;
  localparam logic [WORD_W-1:0] REG0_N_CLEAR   = 32'h8000_7FFF;
  localparam int REG4_DIV_LSB = 20;
  localparam int REG0_N_LSB   = 15;

  // Exponent thresholds (freq below the value selects the exponent).
  localparam logic [FREQ_W-1:0] THR_E7 = 16'd469;
  localparam logic [FREQ_W-1:0] THR_E6 = 16'd938;
  localparam logic [FREQ_W-1:0] THR_E5 = 16'd1875;
  localparam logic [FREQ_W-1:0] THR_E4 = 16'd3750;
  localparam logic [FREQ_W-1:0] THR_E3 = 16'd7500;
  localparam logic [FREQ_W-1:0] THR_E2 = 16'd15000;
  localparam logic [FREQ_W-1:0] THR_E1 = 16'd30000;

  // Configuration register indexes.
  localparam logic [CIDX_W-1:0] CFG_REF_DIVIDER = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_REG0_BASE   = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_REG4_BASE   = 2'd2;

  typedef struct packed {
    logic [RDIV_W-1:0] ref_divider;
    logic [WORD_W-1:0] reg0_base;
    logic [WORD_W-1:0] reg4_base;
  } pdw_cfg_t;

  // One classified request as it sits in the queue.
  typedef struct packed {
    logic [FREQ_W-1:0] vco;
    logic [PFD_W-1:0]  pfd;
    logic [EXP_W-1:0]  exp;
    logic              err;
  } pdw_item_t;

  function automatic logic [EXP_W-1:0] pick_exp(input logic [FREQ_W-1:0] f);
    logic [EXP_W-1:0] e;
    if (f < THR_E7) begin
      e = 3'd7;
    end else if (f < THR_E6) begin
      e = 3'd6;
    end else if (f < THR_E5) begin
      e = 3'd5;
    end else if (f < THR_E4) begin
      e = 3'd4;
    end else if (f < THR_E3) begin
      e = 3'd3;
    end else if (f < THR_E2) begin
      e = 3'd2;
    end else if (f < THR_E1) begin
      e = 3'd1;
    end else begin
      e = 3'd0;
    end
    return e;
  endfunction

  // Phase detector frequency, 192 / r rounded down, as a range table.
  // Out-of-range dividers return 1 so the divider never sees zero.
  function automatic logic [PFD_W-1:0] pfd_lookup(input logic [RDIV_W-1:0] r);
    logic [PFD_W-1:0] p;
    if (r == 10'd0 || r > XTAL_UNITS) p = 8'd1;
    else if (r == 10'd1)  p = 8'd192;
    else if (r == 10'd2)  p = 8'd96;
    else if (r == 10'd3)  p = 8'd64;
    else if (r == 10'd4)  p = 8'd48;
    else if (r == 10'd5)  p = 8'd38;
    else if (r == 10'd6)  p = 8'd32;
    else if (r == 10'd7)  p = 8'd27;
    else if (r == 10'd8)  p = 8'd24;
    else if (r == 10'd9)  p = 8'd21;
    else if (r == 10'd10) p = 8'd19;
    else if (r == 10'd11) p = 8'd17;
    else if (r == 10'd12) p = 8'd16;
    else if (r == 10'd13) p = 8'd14;
    else if (r == 10'd14) p = 8'd13;
    else if (r <= 10'd16) p = 8'd12;
    else if (r == 10'd17) p = 8'd11;
    else if (r <= 10'd19) p = 8'd10;
    else if (r <= 10'd21) p = 8'd9;
    else if (r <= 10'd24) p = 8'd8;
    else if (r <= 10'd27) p = 8'd7;
    else if (r <= 10'd32) p = 8'd6;
    else if (r <= 10'd38) p = 8'd5;
    else if (r <= 10'd48) p = 8'd4;
    else if (r <= 10'd64) p = 8'd3;
    else if (r <= 10'd96) p = 8'd2;
    else                  p = 8'd1;
    return p;
  endfunction

endpackage

// ===== rtl/pdw_front.sv =====
// ----------------------------------------------------------------------------
// pdw_front
// Accepts frequency requests, picks the exponent, forms VCO and PFD values.
// ----------------------------------------------------------------------------
module pdw_front import pdw_pkg::*; (
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FREQ_W-1:0] in_freq,
  input  pdw_cfg_t          cfg,
  input  logic              q_full,
  output logic              q_push,
  output pdw_item_t         q_item
);

  logic [EXP_W-1:0] exp;

  assign exp      = pick_exp(in_freq);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_item.exp = exp;
    // The shift never overflows: small requests get the large exponents.
    q_item.vco = in_freq << exp;
    q_item.pfd = pfd_lookup(cfg.ref_divider);
    q_item.err = (cfg.ref_divider == '0) || (cfg.ref_divider > XTAL_UNITS);
  end

endmodule

// ===== rtl/pdw_fifo.sv =====
// ----------------------------------------------------------------------------
// pdw_fifo
// Short queue of classified requests between the front and the divider.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdw_fifo import pdw_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  pdw_item_t push_item,
  output logic      full,
  input  logic      pop,
  output logic      head_valid,
  output pdw_item_t head_item
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  pdw_item_t        mem_r [0:DEPTH-1];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

  `PDW_ASSERT_NXT(a_fifo_cnt_up, push && !pop, count_r == $past(count_r) + 1'b1, "fifo count did not rise on push")
  `PDW_ASSERT_NXT(a_fifo_cnt_dn, pop && !push, count_r == $past(count_r) - 1'b1, "fifo count did not fall on pop")

endmodule

// ===== rtl/pdw_back.sv =====
// ----------------------------------------------------------------------------
// pdw_back
// Pipelined N divider, four quotient bits per stage, and result register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pdw_back import pdw_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              head_valid,
  input  pdw_item_t         head_item,
  output logic              pop,
  input  pdw_cfg_t          cfg,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_reg4_word,
  output logic [WORD_W-1:0] out_reg0_word,
  output logic [EXP_W-1:0]  out_out_div_exp,
  output logic [FREQ_W-1:0] out_n_value,
  output logic              out_div_error
);

  typedef struct packed {
    logic [FREQ_W-1:0] vco;
    logic [FREQ_W-1:0] q;
    logic [PFD_W-1:0]  rem;
    logic [PFD_W-1:0]  pfd;
    logic [EXP_W-1:0]  exp;
    logic              err;
  } stg_t;

  // Restoring division over CHUNK dividend bits; remainder stays below pfd.
  function automatic logic [CHUNK+PFD_W-1:0] div_chunk(
    input logic [PFD_W-1:0] rem_in,
    input logic [CHUNK-1:0] bits,
    input logic [PFD_W-1:0] d
  );
    logic [PFD_W:0]   t;
    logic [PFD_W-1:0] rem;
    logic [CHUNK-1:0] q;
    rem = rem_in;
    q   = '0;
    for (int i = CHUNK - 1; i >= 0; i--) begin
      t = {rem, bits[i]};
      if (t >= {1'b0, d}) begin
        q[i] = 1'b1;
        t    = t - {1'b0, d};
      end
      rem = t[PFD_W-1:0];
    end
    return {q, rem};
  endfunction

  stg_t              stg_r [0:NSTG-2];
  logic              vld_r [0:NSTG-2];
  stg_t              src   [0:NSTG-1];
  stg_t              res   [0:NSTG-1];
  logic              rdy   [0:NSTG-1];
  logic              out_valid_r;
  logic [WORD_W-1:0] out_reg4_word_r, out_reg4_word_nxt;
  logic [WORD_W-1:0] out_reg0_word_r, out_reg0_word_nxt;
  logic [EXP_W-1:0]  out_exp_r;
  logic [FREQ_W-1:0] out_n_r, out_n_nxt;
  logic              out_err_r;

  // Stage sources and the quotient chunk each stage resolves.
  always_comb begin
    logic [CHUNK+PFD_W-1:0] dc;
    src[0].vco = head_item.vco;
    src[0].q   = '0;
    src[0].rem = '0;
    src[0].pfd = head_item.pfd;
    src[0].exp = head_item.exp;
    src[0].err = head_item.err;
    for (int k = 1; k < NSTG; k++) begin
      src[k] = stg_r[k-1];
    end
    for (int k = 0; k < NSTG; k++) begin
      res[k] = src[k];
      dc = div_chunk(src[k].rem, src[k].vco[FREQ_W-1-k*CHUNK -: CHUNK], src[k].pfd);
      res[k].q[FREQ_W-1-k*CHUNK -: CHUNK] = dc[CHUNK+PFD_W-1 -: CHUNK];
      res[k].rem = dc[PFD_W-1:0];
    end
  end

  // Backpressure: a stage advances when empty or when the next one does.
  always_comb begin
    rdy[NSTG-1] = !out_valid_r || !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
  end

  assign pop = head_valid && rdy[0];

  always_comb begin
    out_n_nxt = res[NSTG-1].err ? '0 : res[NSTG-1].q;
    if (res[NSTG-1].err) begin
      out_reg4_word_nxt = cfg.reg4_base;
      out_reg0_word_nxt = cfg.reg0_base;
    end else begin
      out_reg4_word_nxt = (cfg.reg4_base & REG4_DIV_CLEAR)
                        | (WORD_W'(res[NSTG-1].exp) << REG4_DIV_LSB);
      out_reg0_word_nxt = (cfg.reg0_base & REG0_N_CLEAR)
                        | (WORD_W'(res[NSTG-1].q) << REG0_N_LSB);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NSTG - 1; k++) begin
        vld_r[k] <= 1'b0;
      end
      out_valid_r <= 1'b0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= head_valid;
      end
      for (int k = 1; k < NSTG - 1; k++) begin
        if (rdy[k]) begin
          vld_r[k] <= vld_r[k-1];
        end
      end
      if (rdy[NSTG-1]) begin
        out_valid_r <= vld_r[NSTG-2];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NSTG - 1; k++) begin
      if (rdy[k]) begin
        stg_r[k] <= res[k];
      end
    end
    if (rdy[NSTG-1] && vld_r[NSTG-2]) begin
      out_reg4_word_r <= out_reg4_word_nxt;
      out_reg0_word_r <= out_reg0_word_nxt;
      out_exp_r       <= res[NSTG-1].exp;
      out_n_r         <= out_n_nxt;
      out_err_r       <= res[NSTG-1].err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_reg4_word   = out_reg4_word_r;
  assign out_reg0_word   = out_reg0_word_r;
  assign out_out_div_exp = out_exp_r;
  assign out_n_value     = out_n_r;
  assign out_div_error   = out_err_r;

  `PDW_ASSERT_IMP(a_err_n_zero, out_valid_r && out_err_r, out_n_r == '0, "error beat with nonzero N")
  `PDW_ASSERT_IMP(a_exp_field, out_valid_r && !out_err_r, out_reg4_word_r[22:20] == out_exp_r, "reg4 divider field mismatch")

endmodule

// ===== rtl/pll_divider_word_calc_unit.sv =====
// ----------------------------------------------------------------------------
// pll_divider_word_calc_unit
// Turns a requested frequency into synthesizer register 4 and register 0 words.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: present in_freq (100 kHz units) with in_valid; a beat is
//   taken on a clock edge where in_valid is high and in_stall is low.
//   Output channel: each input beat yields exactly one result beat, in order,
//   on out_valid; the receiver holds it with out_stall. While stalled the
//   result beat and its fields stay put.
//   Configuration: pulse cfg_we with cfg_index / cfg_data while no request is
//   in flight: index 0 reference divider, 1 register-0 base, 2 register-4
//   base. Other indexes are ignored.
//   Throughput: one beat per cycle when not stalled. The front classifies a
//   request in the cycle it arrives; the back resolves N in four pipelined
//   divider stages of four quotient bits each, the last one feeding the
//   output register. A short queue sits between front and back, so in_stall
//   only rises when the queue is full after the output side has stalled for
//   a while.
//   Reset: synchronous active-low rst_n empties the queue and pipeline and
//   sets the reference divider to 1 and both base words to 0.
// ----------------------------------------------------------------------------
module pll_divider_word_calc_unit import pdw_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [FREQ_W-1:0] in_freq,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [WORD_W-1:0] out_reg4_word,
  output logic [WORD_W-1:0] out_reg0_word,
  output logic [EXP_W-1:0]  out_out_div_exp,
  output logic [FREQ_W-1:0] out_n_value,
  output logic              out_div_error,
  // configuration write port
  input  logic              cfg_we,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0] cfg_data
);

  pdw_cfg_t  cfg_r, cfg_nxt;
  logic      q_full;
  logic      q_push;
  logic      q_pop;
  logic      q_head_valid;
  pdw_item_t q_push_item;
  pdw_item_t q_head_item;

  // Register writes: decode the index, drop anything unknown.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_REF_DIVIDER: cfg_nxt.ref_divider = cfg_data[RDIV_W-1:0];
        CFG_REG0_BASE:   cfg_nxt.reg0_base   = cfg_data;
        CFG_REG4_BASE:   cfg_nxt.reg4_base   = cfg_data;
        default:         cfg_nxt             = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ref_divider <= RDIV_W'(1);
      cfg_r.reg0_base   <= '0;
      cfg_r.reg4_base   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front: accept and classify the request.
  pdw_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_freq  (in_freq),
    .cfg      (cfg_r),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_push_item)
  );

  // Queue: decouple front and divider pipeline.
  pdw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  // Back: divide, build the words, hold the result beat.
  pdw_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head_item       (q_head_item),
    .pop             (q_pop),
    .cfg             (cfg_r),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_reg4_word   (out_reg4_word),
    .out_reg0_word   (out_reg0_word),
    .out_out_div_exp (out_out_div_exp),
    .out_n_value     (out_n_value),
    .out_div_error   (out_div_error)
  );

endmodule

// ===== sim/pll_divider_word_calc_unit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pll_divider_word_calc_unit_tb
// Drives frequency requests through the PLL divider word calculator and
// checks every result beat against a local computation of the exponent,
// N divider and merged register words, across many divider and base settings.
// ----------------------------------------------------------------------------
module pll_divider_word_calc_unit_tb import pdw_pkg::*;;

  // Index that maps to no register; writes to it must be ignored.
  localparam logic [CIDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam int PIPE_LATENCY = 4;
  localparam int STALL_LIMIT  = 5000;   // cycles with no beat on either side
  localparam int PRESSURE_AT  = 600;    // input beats before the long hold-off
  localparam int HOLD_CYCLES  = 80;
  localparam int RAND_PHASES  = 19;
  localparam int PHASE_ITEMS  = 105;

  typedef struct packed {
    logic [WORD_W-1:0] reg4_word;
    logic [WORD_W-1:0] reg0_word;
    logic [EXP_W-1:0]  div_exp;
    logic [FREQ_W-1:0] n_value;
    logic              div_error;
  } pll_words_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [FREQ_W-1:0] in_freq = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [WORD_W-1:0] out_reg4_word;
  logic [WORD_W-1:0] out_reg0_word;
  logic [EXP_W-1:0]  out_out_div_exp;
  logic [FREQ_W-1:0] out_n_value;
  logic              out_div_error;
  logic              cfg_we = 1'b0;
  logic [CIDX_W-1:0] cfg_index = CFG_REF_DIVIDER;
  logic [WORD_W-1:0] cfg_data = '0;

  // Local copy of the programmed registers, matching the reset values.
  logic [RDIV_W-1:0] ref_div_shadow = 10'd1;
  logic [WORD_W-1:0] reg0_shadow = '0;
  logic [WORD_W-1:0] reg4_shadow = '0;

  logic [FREQ_W-1:0] freq_backlog[$];
  pll_words_t        expected_words[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int beats_in = 0;
  int hold_left = 0;
  bit pressure_done = 1'b0;
  int quiet_cycles = 0;
  int errors = 0;

  pll_divider_word_calc_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_freq        (in_freq),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_reg4_word  (out_reg4_word),
    .out_reg0_word  (out_reg0_word),
    .out_out_div_exp(out_out_div_exp),
    .out_n_value    (out_n_value),
    .out_div_error  (out_div_error),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Compute the divider words for one request from the shadow registers.
  function automatic pll_words_t calc_pll_words(input logic [FREQ_W-1:0] f);
    pll_words_t w;
    int unsigned e;
    int unsigned pfd;
    int unsigned n;
    if (f < 469)        e = 7;
    else if (f < 938)   e = 6;
    else if (f < 1875)  e = 5;
    else if (f < 3750)  e = 4;
    else if (f < 7500)  e = 3;
    else if (f < 15000) e = 2;
    else if (f < 30000) e = 1;
    else                e = 0;
    w.div_exp = e[EXP_W-1:0];
    if (ref_div_shadow == 0 || ref_div_shadow > 192) begin
      // Phase detector frequency would be zero: flag it, pass the bases through.
      w.div_error = 1'b1;
      w.n_value   = '0;
      w.reg4_word = reg4_shadow;
      w.reg0_word = reg0_shadow;
    end else begin
      pfd = 192 / ref_div_shadow;
      n   = (int'(f) << e) / pfd;
      w.div_error = 1'b0;
      w.n_value   = n[FREQ_W-1:0];
      w.reg4_word = (reg4_shadow & 32'hFF8F_FFFF) | (32'(e) << 20);
      w.reg0_word = (reg0_shadow & 32'h8000_7FFF) | (32'(n[FREQ_W-1:0]) << 15);
    end
    return w;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                             input logic [WORD_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h got %h", $time, name, exp_v, got_v);
      errors++;
    end
  endtask

  // Driver: load the next request from the backlog, hold it while stalled.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_words.push_back(calc_pll_words(in_freq));
        beats_in <= beats_in + 1;
      end
      if (in_valid && in_stall) begin
        // hold the stalled beat as it is
      end else if (freq_backlog.size() != 0 &&
                   (hold_left != 0 || $urandom_range(0, 99) >= tx_idle_pct)) begin
        // Never idle during the long hold-off so the block fills up.
        in_valid <= 1'b1;
        in_freq  <= freq_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall: random back-pressure plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (!pressure_done && beats_in >= PRESSURE_AT) begin
      out_stall     <= 1'b1;
      hold_left     <= HOLD_CYCLES;
      pressure_done <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end
  end

  // Monitor: compare every result beat with the oldest expectation.
  always @(posedge clk) begin
    pll_words_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_words.size() == 0) begin
        $display("%0t: result beat with nothing expected, got %h %h %h %h %h", $time,
                 out_reg4_word, out_reg0_word, out_out_div_exp, out_n_value,
                 out_div_error);
        errors++;
      end else begin
        w = expected_words.pop_front();
        check_field("reg4_word", w.reg4_word, out_reg4_word);
        check_field("reg0_word", w.reg0_word, out_reg0_word);
        check_field("out_div_exp", 32'(w.div_exp), 32'(out_out_div_exp));
        check_field("n_value", 32'(w.n_value), 32'(out_n_value));
        check_field("div_error", 32'(w.div_error), 32'(out_div_error));
      end
    end
  end

  // Watchdog: give up when neither side moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Wait until every queued request has gone out and every result is back,
  // then let the pipeline settle.
  task automatic wait_drained();
    while (freq_backlog.size() != 0 || in_valid || expected_words.size() != 0)
      @(negedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // Program all registers; optionally poke the unused index as well.
  task automatic program_plan(input logic [WORD_W-1:0] rdiv, input logic [WORD_W-1:0] r0,
                              input logic [WORD_W-1:0] r4, input bit poke_unused);
    @(posedge clk);
    cfg_we <= 1'b1; cfg_index <= CFG_REF_DIVIDER; cfg_data <= rdiv;
    ref_div_shadow = rdiv[RDIV_W-1:0];
    @(posedge clk);
    cfg_index <= CFG_REG0_BASE; cfg_data <= r0;
    reg0_shadow = r0;
    @(posedge clk);
    cfg_index <= CFG_REG4_BASE; cfg_data <= r4;
    reg4_shadow = r4;
    if (poke_unused) begin
      @(posedge clk);
      cfg_index <= CFG_UNUSED; cfg_data <= $urandom;
    end
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int thr[8];
    int k;
    int lo;
    int hi;
    logic [WORD_W-1:0] rdiv;
    logic [WORD_W-1:0] b0;
    logic [WORD_W-1:0] b4;
    thr = '{0, 469, 938, 1875, 3750, 7500, 15000, 30000};

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    tx_idle_pct <= 35;
    rx_idle_pct <= 69;

    // Reset settings: both extremes and both sides of every exponent threshold.
    @(negedge clk);
    freq_backlog = '{16'd0, 16'd468, 16'd469, 16'd937, 16'd938, 16'd1874, 16'd1875,
                     16'd3749, 16'd3750, 16'd7499, 16'd7500, 16'd14999, 16'd15000,
                     16'd29999, 16'd30000, 16'hFFFF};
    wait_drained();

    // Largest valid divider (pfd of one), all-ones bases, unused index poked.
    program_plan(32'd192, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    @(negedge clk);
    freq_backlog = '{16'hFFFF, 16'd468};
    wait_drained();

    // Divider of zero: error, bases pass through.
    program_plan(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    @(negedge clk);
    freq_backlog = '{16'd1000, 16'hFFFF};
    wait_drained();

    // Just above the valid range, then the largest register value.
    program_plan(32'd193, 32'h0000_0000, 32'h1234_5678, 1'b0);
    @(negedge clk);
    freq_backlog = '{16'd0, 16'd40000};
    wait_drained();
    program_plan(32'd1023, 32'h8765_4321, 32'h0000_0000, 1'b0);
    @(negedge clk);
    freq_backlog = '{16'd12345};
    wait_drained();

    // Uneven pfd (192/7 = 27) with the top request.
    program_plan(32'd7, 32'h0, 32'h0, 1'b0);
    @(negedge clk);
    freq_backlog = '{16'hFFFF, 16'd29999};
    wait_drained();

    // Random phases, each with fresh register settings.
    for (int p = 0; p < RAND_PHASES; p++) begin
      if (p < 6) begin
        tx_idle_pct <= 35; rx_idle_pct <= 69;
      end else if (p < 12) begin
        tx_idle_pct <= 69; rx_idle_pct <= 35;
      end else begin
        tx_idle_pct <= 0; rx_idle_pct <= 0;
      end
      case ($urandom_range(0, 9))
        0: rdiv = 32'd0;
        1: rdiv = $urandom_range(1023, 193);
        2: rdiv = 32'd1;
        3: rdiv = 32'd192;
        4: rdiv = 32'd1023;
        default: rdiv = $urandom_range(192, 1);
      endcase
      // Upper junk bits above the 10-bit divider must be dropped.
      if ($urandom_range(0, 3) == 0) rdiv[WORD_W-1:RDIV_W] = (WORD_W-RDIV_W)'($urandom);
      b0 = ($urandom_range(0, 5) == 0) ? 32'hFFFF_FFFF : $urandom;
      b4 = ($urandom_range(0, 5) == 0) ? 32'h0 : $urandom;
      program_plan(rdiv, b0, b4, $urandom_range(0, 3) == 0);
      @(negedge clk);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        case ($urandom_range(0, 3))
          0: freq_backlog.push_back(FREQ_W'($urandom));
          1: begin
            k  = $urandom_range(0, 7);
            lo = thr[k];
            hi = (k == 7) ? 65535 : thr[k + 1] - 1;
            freq_backlog.push_back(FREQ_W'($urandom_range(hi, lo)));
          end
          2: begin
            k = $urandom_range(1, 7);
            freq_backlog.push_back(FREQ_W'(thr[k] - 2 + $urandom_range(0, 3)));
          end
          default: freq_backlog.push_back(FREQ_W'($urandom_range(468, 0)));
        endcase
      end
      wait_drained();
    end

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/pdw_pkg.sv
rtl/pdw_front.sv
rtl/pdw_fifo.sv
rtl/pdw_back.sv
rtl/pll_divider_word_calc_unit.sv
sim/pll_divider_word_calc_unit_tb.sv
